// ===== design/c8ise_pkg.sv =====
// c8ise_pkg: shared constants, types and helper functions of the chip8 subset executor
// used by the controller, the datapath, the top level and the checker; no dependencies
`timescale 1ns / 1ps
`default_nettype none

package c8ise_pkg;

   // storage geometry; memory size must stay a power of two (512 to 4096)
   localparam int MEM_AW    = 12;
   localparam int MEM_BYTES = 1 << MEM_AW;
   localparam int ADDR_W    = 12;
   localparam int DISP_W    = 64;
   localparam int DISP_H    = 32;
   localparam int ROW_W     = $clog2(DISP_H);
   localparam int COL_W     = $clog2(DISP_W);
   localparam int CSR_IDX_W = 1;
   localparam int CSR_W     = 16;

   // reset values
   localparam logic [ADDR_W-1:0] PC_RESET      = 12'd512;
   localparam logic [15:0]       SEED_FALLBACK = 16'd44257;

   // request kinds
   localparam logic [1:0] REQ_LOAD = 2'd0;
   localparam logic [1:0] REQ_EXEC = 2'd1;
   localparam logic [1:0] REQ_READ = 2'd2;

   // configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_START_ADDRESS = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_RANDOM_SEED   = 1'b1;

   // opcode classes (top nibble)
   localparam logic [3:0] OPC_JUMP      = 4'h1;
   localparam logic [3:0] OPC_SKIP_EQ   = 4'h3;
   localparam logic [3:0] OPC_ADD_IMM   = 4'h7;
   localparam logic [3:0] OPC_SET_INDEX = 4'hA;
   localparam logic [3:0] OPC_RANDOM    = 4'hC;
   localparam logic [3:0] OPC_DRAW      = 4'hD;

   localparam logic [3:0] VF_INDEX = 4'hF;

   // memory read address select
   typedef logic [1:0] rd_sel_type;
   localparam rd_sel_type RD_PC           = 2'd0;
   localparam rd_sel_type RD_PC_NEXT      = 2'd1;
   localparam rd_sel_type RD_SPRITE_FIRST = 2'd2;
   localparam rd_sel_type RD_SPRITE_NEXT  = 2'd3;

   // controller to datapath commands
   typedef struct packed {
      logic       capture_req;
      logic       clear_wr;
      logic       load_wr;
      rd_sel_type rd_sel;
      logic       cap_hi;
      logic       cap_lo;
      logic       exec;
      logic       draw_start;
      logic       draw_row;
      logic       draw_end;
      logic       rsp_load;
   } dp_cmd_type;

   // datapath to controller status
   typedef struct packed {
      logic       is_draw;
      logic       n_zero;
      logic       draw_last;
      logic       clear_last;
   } dp_stat_type;

   // fibonacci lfsr x^16+x^14+x^13+x^11+1, shifting right
   function automatic logic [15:0] lfsr_next(input logic [15:0] v);
      logic fb;
      fb = v[0] ^ v[2] ^ v[3] ^ v[5];
      return {fb, v[15:1]};
   endfunction

   function automatic logic is_implemented(input logic [3:0] nib);
      return (nib == OPC_JUMP) || (nib == OPC_SKIP_EQ) || (nib == OPC_ADD_IMM) ||
             (nib == OPC_SET_INDEX) || (nib == OPC_RANDOM) || (nib == OPC_DRAW);
   endfunction

endpackage

`default_nettype wire

// ===== design/c8ise_dpath.sv =====
// c8ise_dpath: program memory, general registers, pc, index, lfsr, display rows
// and the result register; driven by c8ise_ctrl commands, uses c8ise_pkg
`timescale 1ns / 1ps
`default_nettype none

module c8ise_dpath (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic [1:0]                       req_type,
   input  wire logic [c8ise_pkg::ADDR_W-1:0]     req_address,
   input  wire logic [7:0]                       req_data,
   input  wire logic [c8ise_pkg::ROW_W-1:0]      req_row,
   input  wire logic                             csr_we,
   input  wire logic [c8ise_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [c8ise_pkg::CSR_W-1:0]      csr_wdata,
   input  wire c8ise_pkg::dp_cmd_type            cmd,
   output c8ise_pkg::dp_stat_type                stat,
   output logic [c8ise_pkg::ADDR_W-1:0]          rsp_pc_out,
   output logic [15:0]                           rsp_opcode_out,
   output logic                                  rsp_status,
   output logic [c8ise_pkg::ADDR_W-1:0]          rsp_index_out,
   output logic [c8ise_pkg::DISP_W-1:0]          rsp_row_bits
);
   import c8ise_pkg::*;

   logic [1:0]              kind_ff;
   logic [ADDR_W-1:0]       addr_ff;
   logic [7:0]              data_ff;
   logic [ROW_W-1:0]        row_ff;

   logic [7:0]              mem [MEM_BYTES];
   logic [7:0]              mem_rdata_ff;
   logic                    mem_we;
   logic [MEM_AW-1:0]       mem_waddr;
   logic [7:0]              mem_wdata;
   logic [ADDR_W-1:0]       rd_addr;
   logic [MEM_AW-1:0]       clr_cnt_ff;

   logic [7:0]              op_hi_ff;
   logic [7:0]              op_lo_ff;
   logic [15:0]             opcode;
   logic [3:0]              op_nib;
   logic [3:0]              op_x;
   logic [3:0]              op_y;
   logic [3:0]              op_n;
   logic [7:0]              op_nn;
   logic [ADDR_W-1:0]       op_nnn;

   logic [7:0]              gpr_ff [16];
   logic [3:0]              gpr_raddr;
   logic [7:0]              gpr_rd;
   logic                    gpr_we;
   logic [3:0]              gpr_waddr;
   logic [7:0]              gpr_wdata;

   logic [ADDR_W-1:0]       pc_ff, pc_in;
   logic [ADDR_W-1:0]       index_ff, index_in;
   logic [15:0]             lfsr_ff, lfsr_in;
   logic [15:0]             lfsr_step;

   logic [7:0]              vx_ff;
   logic [7:0]              vy_ff;
   logic [3:0]              cnt_ff;
   logic                    hit_ff;

   logic [DISP_W-1:0]       display_ff [DISP_H];
   logic [ROW_W-1:0]        disp_raddr;
   logic [DISP_W-1:0]       disp_rd;
   logic [DISP_W-1:0]       sprite_line;
   logic [2*DISP_W-1:0]     sprite_rot;
   logic [DISP_W-1:0]       sprite_mask;

   logic                    is_exec;

   // request capture
   always_ff @(posedge clock) begin
      if (cmd.capture_req) begin
         kind_ff <= req_type;
         addr_ff <= req_address;
         data_ff <= req_data;
         row_ff  <= req_row;
      end
   end

   // clearing pass counter
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_cnt_ff <= '0;
      end else if (cmd.clear_wr) begin
         clr_cnt_ff <= clr_cnt_ff + 1'b1;
      end
   end

   // memory port selection
   always_comb begin
      mem_we    = cmd.clear_wr | cmd.load_wr;
      mem_waddr = cmd.clear_wr ? clr_cnt_ff : addr_ff[MEM_AW-1:0];
      mem_wdata = cmd.clear_wr ? 8'd0 : data_ff;
      unique case (cmd.rd_sel)
         RD_PC:           rd_addr = pc_ff;
         RD_PC_NEXT:      rd_addr = pc_ff + 1'b1;
         RD_SPRITE_FIRST: rd_addr = index_ff;
         default:         rd_addr = index_ff + {{(ADDR_W-4){1'b0}}, cnt_ff} + 1'b1;
      endcase
   end

   // program memory, one write and one registered read
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      mem_rdata_ff <= mem[rd_addr[MEM_AW-1:0]];
   end

   // instruction word
   always_ff @(posedge clock) begin
      if (cmd.cap_hi) begin
         op_hi_ff <= mem_rdata_ff;
      end
      if (cmd.cap_lo) begin
         op_lo_ff <= mem_rdata_ff;
      end
   end

   assign opcode = {op_hi_ff, op_lo_ff};
   assign op_nib = opcode[15:12];
   assign op_x   = opcode[11:8];
   assign op_y   = opcode[7:4];
   assign op_n   = opcode[3:0];
   assign op_nn  = opcode[7:0];
   assign op_nnn = opcode[11:0];

   // single read port on the general registers
   assign gpr_raddr = cmd.draw_start ? op_y : op_x;
   assign gpr_rd    = gpr_ff[gpr_raddr];
   assign lfsr_step = lfsr_next(lfsr_ff);

   // general register write
   always_comb begin
      gpr_we    = 1'b0;
      gpr_waddr = op_x;
      gpr_wdata = gpr_rd + op_nn;
      if (cmd.exec && (op_nib == OPC_ADD_IMM)) begin
         gpr_we = 1'b1;
      end else if (cmd.exec && (op_nib == OPC_RANDOM)) begin
         gpr_we    = 1'b1;
         gpr_wdata = lfsr_step[7:0] & op_nn;
      end else if (cmd.draw_end) begin
         gpr_we    = 1'b1;
         gpr_waddr = VF_INDEX;
         gpr_wdata = {7'd0, hit_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 16; i++) begin
            gpr_ff[i] <= 8'd0;
         end
      end else if (gpr_we) begin
         gpr_ff[gpr_waddr] <= gpr_wdata;
      end
   end

   // pc, index and lfsr next values
   always_comb begin
      pc_in    = pc_ff;
      index_in = index_ff;
      lfsr_in  = lfsr_ff;
      if (csr_we && (csr_index == CSR_START_ADDRESS)) begin
         pc_in = csr_wdata[ADDR_W-1:0];
      end
      if (csr_we && (csr_index == CSR_RANDOM_SEED)) begin
         lfsr_in = (csr_wdata != 16'd0) ? csr_wdata : SEED_FALLBACK;
      end
      if (cmd.exec) begin
         unique case (op_nib)
            OPC_JUMP: begin
               pc_in = op_nnn;
            end
            OPC_SKIP_EQ: begin
               pc_in = (gpr_rd == op_nn) ? pc_ff + 12'd4 : pc_ff + 12'd2;
            end
            OPC_SET_INDEX: begin
               index_in = op_nnn;
               pc_in    = pc_ff + 12'd2;
            end
            OPC_RANDOM: begin
               lfsr_in = lfsr_step;
               pc_in   = pc_ff + 12'd2;
            end
            OPC_DRAW: begin
               pc_in = pc_ff;
            end
            default: begin
               pc_in = pc_ff + 12'd2;
            end
         endcase
      end
      if (cmd.draw_end) begin
         pc_in = pc_ff + 12'd2;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff    <= PC_RESET;
         index_ff <= '0;
         lfsr_ff  <= SEED_FALLBACK;
      end else begin
         pc_ff    <= pc_in;
         index_ff <= index_in;
         lfsr_ff  <= lfsr_in;
      end
   end

   // sprite row: rotate the byte right by the x coordinate so columns wrap
   assign disp_raddr  = cmd.draw_row ? vy_ff[ROW_W-1:0] + {1'b0, cnt_ff} : row_ff;
   assign disp_rd     = display_ff[disp_raddr];
   assign sprite_line = {mem_rdata_ff, {(DISP_W-8){1'b0}}};
   assign sprite_rot  = {sprite_line, sprite_line} >> vx_ff[COL_W-1:0];
   assign sprite_mask = sprite_rot[DISP_W-1:0];

   // draw coordinates, row counter and collision flag
   always_ff @(posedge clock) begin
      if (cmd.exec) begin
         vx_ff <= gpr_rd;
      end
      if (cmd.draw_start) begin
         vy_ff  <= gpr_rd;
         cnt_ff <= 4'd0;
         hit_ff <= 1'b0;
      end else if (cmd.draw_row) begin
         cnt_ff <= cnt_ff + 1'b1;
         hit_ff <= hit_ff | (|(disp_rd & sprite_mask));
      end
   end

   // display rows, xor write
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < DISP_H; i++) begin
            display_ff[i] <= '0;
         end
      end else if (cmd.draw_row) begin
         display_ff[disp_raddr] <= disp_rd ^ sprite_mask;
      end
   end

   // status toward the controller
   assign stat.is_draw    = (op_nib == OPC_DRAW);
   assign stat.n_zero     = (op_n == 4'd0);
   assign stat.draw_last  = (cnt_ff == op_n - 4'd1);
   assign stat.clear_last = (clr_cnt_ff == {MEM_AW{1'b1}});

   // result register
   assign is_exec = (kind_ff == REQ_EXEC);

   always_ff @(posedge clock) begin
      if (cmd.rsp_load) begin
         rsp_pc_out     <= pc_ff;
         rsp_opcode_out <= is_exec ? opcode : 16'd0;
         rsp_status     <= is_exec & ~is_implemented(op_nib);
         rsp_index_out  <= index_ff;
         rsp_row_bits   <= (kind_ff == REQ_READ) ? disp_rd : '0;
      end
   end

endmodule

`default_nettype wire

// ===== design/c8ise_ctrl.sv =====
// c8ise_ctrl: sequencer of the chip8 subset executor, issues datapath commands
// and owns the input ready and result valid; uses c8ise_pkg
`timescale 1ns / 1ps
`default_nettype none

module c8ise_ctrl (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_ready,
   input  wire logic [1:0]             req_type,
   output logic                        rsp_valid,
   input  wire logic                   rsp_ready,
   input  wire c8ise_pkg::dp_stat_type stat,
   output c8ise_pkg::dp_cmd_type       cmd
);
   import c8ise_pkg::*;

   localparam logic [3:0] S_CLEAR    = 4'd0;
   localparam logic [3:0] S_IDLE     = 4'd1;
   localparam logic [3:0] S_LOAD     = 4'd2;
   localparam logic [3:0] S_FETCH_HI = 4'd3;
   localparam logic [3:0] S_FETCH_LO = 4'd4;
   localparam logic [3:0] S_DECODE   = 4'd5;
   localparam logic [3:0] S_EXEC     = 4'd6;
   localparam logic [3:0] S_DRAW_VY  = 4'd7;
   localparam logic [3:0] S_DRAW_ROW = 4'd8;
   localparam logic [3:0] S_DRAW_END = 4'd9;
   localparam logic [3:0] S_DONE     = 4'd10;

   logic [3:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       accept;
   logic       commit;

   assign req_ready = (state_ff == S_IDLE);
   assign accept    = req_valid & req_ready;
   assign commit    = (state_ff == S_DONE) & (~rsp_valid_ff | rsp_ready);
   assign rsp_valid = rsp_valid_ff;

   // result slot: filled on commit, emptied on transfer
   assign rsp_valid_in = commit | (rsp_valid_ff & ~rsp_ready);

   // next state and commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      cmd.rd_sel = RD_PC;
      unique case (state_ff)
         S_CLEAR: begin
            cmd.clear_wr = 1'b1;
            if (stat.clear_last) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            cmd.capture_req = accept;
            if (accept) begin
               unique case (req_type)
                  REQ_LOAD: state_in = S_LOAD;
                  REQ_EXEC: state_in = S_FETCH_HI;
                  default:  state_in = S_DONE;
               endcase
            end
         end
         S_LOAD: begin
            cmd.load_wr = 1'b1;
            state_in    = S_DONE;
         end
         S_FETCH_HI: begin
            cmd.rd_sel = RD_PC;
            state_in   = S_FETCH_LO;
         end
         S_FETCH_LO: begin
            cmd.rd_sel = RD_PC_NEXT;
            cmd.cap_hi = 1'b1;
            state_in   = S_DECODE;
         end
         S_DECODE: begin
            cmd.cap_lo = 1'b1;
            state_in   = S_EXEC;
         end
         S_EXEC: begin
            cmd.exec = 1'b1;
            state_in = stat.is_draw ? S_DRAW_VY : S_DONE;
         end
         S_DRAW_VY: begin
            cmd.draw_start = 1'b1;
            cmd.rd_sel     = RD_SPRITE_FIRST;
            state_in       = stat.n_zero ? S_DRAW_END : S_DRAW_ROW;
         end
         S_DRAW_ROW: begin
            cmd.draw_row = 1'b1;
            cmd.rd_sel   = RD_SPRITE_NEXT;
            if (stat.draw_last) begin
               state_in = S_DRAW_END;
            end
         end
         S_DRAW_END: begin
            cmd.draw_end = 1'b1;
            state_in     = S_DONE;
         end
         S_DONE: begin
            cmd.rsp_load = commit;
            if (commit) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

`default_nettype wire

// ===== design/chip8_instruction_subset_executor_unit.sv =====
// chip8_instruction_subset_executor_unit: top level of the chip8 subset executor
// instantiates c8ise_ctrl and c8ise_dpath; uses c8ise_pkg
`timescale 1ns / 1ps
`default_nettype none

// Takes one request at a time and returns one result per request. After reset the
// program memory is cleared one byte per cycle and req_ready stays low until that pass
// ends; configuration writes are taken at any time. On the way to the result register
// a byte load passes the load state, a display row read goes straight to done, an
// instruction passes fetch high, fetch low, decode and execute, and a sprite draw adds
// a start state, a row state per sprite row and an end state. The one read port of the
// program memory returns the instruction bytes and each sprite row one per cycle. A
// new request is taken once the previous one has reached the result register, even if
// that result is not yet transferred. Writing start_address loads the program counter;
// writing random_seed loads the random generator (zero stands for the default seed).
module chip8_instruction_subset_executor_unit (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_valid,
   output logic                                  req_ready,
   input  wire logic [1:0]                       req_type,
   input  wire logic [c8ise_pkg::ADDR_W-1:0]     req_address,
   input  wire logic [7:0]                       req_data,
   input  wire logic [c8ise_pkg::ROW_W-1:0]      req_row,
   output logic                                  rsp_valid,
   input  wire logic                             rsp_ready,
   output logic [c8ise_pkg::ADDR_W-1:0]          rsp_pc_out,
   output logic [15:0]                           rsp_opcode_out,
   output logic                                  rsp_status,
   output logic [c8ise_pkg::ADDR_W-1:0]          rsp_index_out,
   output logic [c8ise_pkg::DISP_W-1:0]          rsp_row_bits,
   input  wire logic                             csr_valid,
   output logic                                  csr_ready,
   input  wire logic [c8ise_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [c8ise_pkg::CSR_W-1:0]      csr_wdata
);
   import c8ise_pkg::*;

   dp_cmd_type  cmd;
   dp_stat_type stat;
   logic        csr_we;

   // configuration writes are always accepted
   assign csr_ready = 1'b1;
   assign csr_we    = csr_valid & csr_ready;

   c8ise_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_type  (req_type),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   c8ise_dpath u_dpath (
      .clock          (clock),
      .reset          (reset),
      .req_type       (req_type),
      .req_address    (req_address),
      .req_data       (req_data),
      .req_row        (req_row),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .cmd            (cmd),
      .stat           (stat),
      .rsp_pc_out     (rsp_pc_out),
      .rsp_opcode_out (rsp_opcode_out),
      .rsp_status     (rsp_status),
      .rsp_index_out  (rsp_index_out),
      .rsp_row_bits   (rsp_row_bits)
   );

endmodule

`default_nettype wire

// ===== design/c8ise_checker.sv =====
// c8ise_checker: port-level assertions on the chip8 subset executor
// bound to chip8_instruction_subset_executor_unit; uses c8ise_pkg
`timescale 1ns / 1ps
`default_nettype none

module c8ise_checker (
   input wire logic                             clock,
   input wire logic                             reset,
   input wire logic                             req_ready,
   input wire logic                             rsp_valid,
   input wire logic                             rsp_ready,
   input wire logic [c8ise_pkg::ADDR_W-1:0]     rsp_pc_out,
   input wire logic [15:0]                      rsp_opcode_out,
   input wire logic                             rsp_status,
   input wire logic [c8ise_pkg::DISP_W-1:0]     rsp_row_bits
);
   import c8ise_pkg::*;

   // memory clearing pass holds off requests right after reset
   a_clear_after_reset: assert property (@(posedge clock)
      reset |=> !req_ready)
      else $error("request taken during memory clearing pass");

   // stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_pc_out) &&
         $stable(rsp_opcode_out) && $stable(rsp_row_bits))
      else $error("stalled result changed");

   // unimplemented status only for opcodes outside the subset
   a_status_class: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status |->
         rsp_opcode_out[15:12] != OPC_JUMP && rsp_opcode_out[15:12] != OPC_SKIP_EQ &&
         rsp_opcode_out[15:12] != OPC_ADD_IMM && rsp_opcode_out[15:12] != OPC_SET_INDEX &&
         rsp_opcode_out[15:12] != OPC_RANDOM && rsp_opcode_out[15:12] != OPC_DRAW &&
         rsp_row_bits == '0)
      else $error("unimplemented status on a supported opcode");

   // jump leaves the pc at its target
   a_jump_target: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_status && rsp_opcode_out[15:12] == OPC_JUMP |->
         rsp_pc_out == rsp_opcode_out[11:0])
      else $error("jump result pc differs from target");

endmodule

bind chip8_instruction_subset_executor_unit c8ise_checker u_c8ise_checker (.*);

`default_nettype wire

// ===== tb/chip8_instruction_subset_executor_unit_tb.sv =====
// testbench for chip8_instruction_subset_executor_unit: loads small programs, steps them and
// reads display rows, checking every result against a shadow copy of the executor state
// depends on c8ise_pkg and the design top level only
`timescale 1ns / 1ps

module chip8_instruction_subset_executor_unit_tb;
   import c8ise_pkg::*;

   // request kind the block has no use for
   localparam logic [1:0] REQ_UNUSED = 2'd3;
   localparam int STALL_LIMIT = 20000;
   localparam int DRAIN_CYCLES = 40;

   typedef struct packed {
      logic [ADDR_W-1:0] pc;
      logic [15:0]       opcode;
      logic              status;
      logic [ADDR_W-1:0] index;
      logic [DISP_W-1:0] row_bits;
   } exec_result_type;

   // shadow of the executor: memory, registers, display and random generator
   class chip8_shadow_type;
      logic [7:0]        memory [MEM_BYTES];
      logic [7:0]        vreg [16];
      logic [ADDR_W-1:0] index_reg;
      logic [ADDR_W-1:0] pc;
      logic [DISP_W-1:0] screen [DISP_H];
      logic [15:0]       lfsr;
      exec_result_type   pending_results[$];
      int unsigned       mismatches;

      function new();
         foreach (memory[i]) memory[i] = 8'h00;
         foreach (vreg[i]) vreg[i] = 8'h00;
         foreach (screen[i]) screen[i] = '0;
         index_reg = '0;
         pc = PC_RESET;
         lfsr = SEED_FALLBACK;
         mismatches = 0;
      endfunction

      function int mem_slot(int a);
         return (a & 'hFFF) % MEM_BYTES;
      endfunction

      function void write_register(logic [CSR_IDX_W-1:0] idx, logic [CSR_W-1:0] wdata);
         if (idx == CSR_START_ADDRESS) begin
            pc = wdata[ADDR_W-1:0];
         end else if (idx == CSR_RANDOM_SEED) begin
            // a zero seed would lock the generator
            lfsr = (wdata != 16'd0) ? wdata : SEED_FALLBACK;
         end
      endfunction

      // xor sprite onto the wrapped display, vf flags any pixel turned off
      function void draw_sprite(int x, int y, int n);
         int vx;
         int vy;
         int r;
         int c;
         logic [7:0] line;
         logic hit;
         vx = vreg[x];
         vy = vreg[y];
         hit = 1'b0;
         for (int i = 0; i < n; i++) begin
            line = memory[mem_slot(index_reg + i)];
            r = (vy + i) % DISP_H;
            for (int j = 0; j < 8; j++) begin
               if (line[7-j]) begin
                  c = (vx + j) % DISP_W;
                  if (screen[r][DISP_W-1-c]) hit = 1'b1;
                  screen[r][DISP_W-1-c] = ~screen[r][DISP_W-1-c];
               end
            end
         end
         vreg[VF_INDEX] = {7'd0, hit};
      endfunction

      // apply one accepted request and queue the result it must produce
      function void note_request(logic [1:0] kind, logic [ADDR_W-1:0] addr, logic [7:0] data,
                                 logic [ROW_W-1:0] row);
         exec_result_type want;
         logic [15:0] op;
         logic [ADDR_W-1:0] next_pc;
         int x;
         int y;
         logic [7:0] nn;
         want = '0;
         if (kind == REQ_LOAD) begin
            memory[mem_slot(addr)] = data;
         end else if (kind == REQ_EXEC) begin
            op = {memory[mem_slot(pc)], memory[mem_slot(pc + 1)]};
            x = op[11:8];
            y = op[7:4];
            nn = op[7:0];
            next_pc = pc + 12'd2;
            case (op[15:12])
               OPC_JUMP: next_pc = op[11:0];
               OPC_SKIP_EQ: begin
                  if (vreg[x] == nn) next_pc = pc + 12'd4;
               end
               OPC_ADD_IMM: vreg[x] = vreg[x] + nn;
               OPC_SET_INDEX: index_reg = op[11:0];
               OPC_RANDOM: begin
                  lfsr = {lfsr[0] ^ lfsr[2] ^ lfsr[3] ^ lfsr[5], lfsr[15:1]};
                  vreg[x] = lfsr[7:0] & nn;
               end
               OPC_DRAW: draw_sprite(x, y, op[3:0]);
               default: want.status = 1'b1;
            endcase
            pc = next_pc;
            want.opcode = op;
         end else if (kind == REQ_READ) begin
            want.row_bits = screen[row];
         end
         want.pc = pc;
         want.index = index_reg;
         pending_results.push_back(want);
      endfunction

      function void check_field(string field, logic [63:0] want, logic [63:0] got);
         if (want !== got) begin
            mismatches++;
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
         end
      endfunction

      function void check_result(exec_result_type got);
         exec_result_type want;
         if (pending_results.size() == 0) begin
            mismatches++;
            $display("%0t: unexpected result, expected none, actual pc %0h opcode %0h",
                     $time, got.pc, got.opcode);
            return;
         end
         want = pending_results.pop_front();
         check_field("pc_out", want.pc, got.pc);
         check_field("opcode_out", want.opcode, got.opcode);
         check_field("status", want.status, got.status);
         check_field("index_out", want.index, got.index);
         check_field("row_bits", want.row_bits, got.row_bits);
      endfunction
   endclass

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_ready;
   logic [1:0]            req_type;
   logic [ADDR_W-1:0]     req_address;
   logic [7:0]            req_data;
   logic [ROW_W-1:0]      req_row;
   logic                  rsp_valid;
   logic                  rsp_ready;
   logic [ADDR_W-1:0]     rsp_pc_out;
   logic [15:0]           rsp_opcode_out;
   logic                  rsp_status;
   logic [ADDR_W-1:0]     rsp_index_out;
   logic [DISP_W-1:0]     rsp_row_bits;
   logic                  csr_valid;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_W-1:0]      csr_wdata;

   chip8_shadow_type sb;
   int send_idle_pct = 0;
   int stall_pct = 0;
   int sent_items = 0;
   int quiet_cycles = 0;

   chip8_instruction_subset_executor_unit u_top (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_type       (req_type),
      .req_address    (req_address),
      .req_data       (req_data),
      .req_row        (req_row),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_pc_out     (rsp_pc_out),
      .rsp_opcode_out (rsp_opcode_out),
      .rsp_status     (rsp_status),
      .rsp_index_out  (rsp_index_out),
      .rsp_row_bits   (rsp_row_bits),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // result side stalls at random
   always @(negedge clock) begin
      rsp_ready = ($urandom_range(99) >= stall_pct);
   end

   // result transfer check
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         sb.check_result({rsp_pc_out, rsp_opcode_out, rsp_status, rsp_index_out, rsp_row_bits});
   end

   // watchdog on cycles without any transfer
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_valid && csr_ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   // one request transfer, with random sender gaps ahead of it
   task automatic send_request(input logic [1:0] kind, input logic [ADDR_W-1:0] addr,
                               input logic [7:0] data, input logic [ROW_W-1:0] row);
      while ($urandom_range(99) < send_idle_pct) begin
         @(negedge clock);
         req_valid = 1'b0;
      end
      @(negedge clock);
      req_valid = 1'b1;
      req_type = kind;
      req_address = addr;
      req_data = data;
      req_row = row;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sb.note_request(kind, addr, data, row);
      sent_items++;
   endtask

   task automatic load_byte(input int addr, input logic [7:0] data);
      send_request(REQ_LOAD, addr[ADDR_W-1:0], data, ROW_W'($urandom));
   endtask

   task automatic load_word(input int addr, input logic [15:0] word);
      load_byte(addr, word[15:8]);
      load_byte(addr + 1, word[7:0]);
   endtask

   task automatic step_once();
      send_request(REQ_EXEC, ADDR_W'($urandom), 8'($urandom), ROW_W'($urandom));
   endtask

   task automatic read_row(input int r);
      send_request(REQ_READ, ADDR_W'($urandom), 8'($urandom), r[ROW_W-1:0]);
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_W-1:0] wdata);
      @(negedge clock);
      csr_valid = 1'b1;
      csr_index = idx;
      csr_wdata = wdata;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      sb.write_register(idx, wdata);
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   task automatic wait_drained();
      @(negedge clock);
      req_valid = 1'b0;
      while (sb.pending_results.size() != 0) @(posedge clock);
   endtask

   // reconfigure while idle, then mostly well-formed programs with random content
   task automatic run_phase(input logic [ADDR_W-1:0] start, input logic [15:0] seed,
                            input int send_pct, input int stall_in, input int count);
      int goal;
      int pick;
      int kind;
      logic [3:0] x;
      logic [3:0] nib;
      logic [7:0] nn;
      logic [3:0] rows;
      logic [15:0] op;
      wait_drained();
      write_csr(CSR_START_ADDRESS, {4'($urandom), start});
      write_csr(CSR_RANDOM_SEED, seed);
      send_idle_pct = send_pct;
      stall_pct = stall_in;
      goal = sent_items + count;
      while (sent_items < goal) begin
         pick = $urandom_range(99);
         if (pick < 60) begin
            kind = $urandom_range(99);
            x = 4'($urandom);
            nn = 8'($urandom);
            rows = ($urandom_range(3) == 0) ? 4'($urandom) : 4'($urandom_range(4));
            if (kind < 10) begin
               op = {OPC_JUMP, 12'($urandom)};
            end else if (kind < 25) begin
               // half of the compares hit so that skips happen
               op = {OPC_SKIP_EQ, x, ($urandom_range(1) != 0) ? sb.vreg[x] : nn};
            end else if (kind < 42) begin
               op = {OPC_ADD_IMM, x, nn};
            end else if (kind < 52) begin
               op = {OPC_SET_INDEX, 12'($urandom)};
            end else if (kind < 64) begin
               op = {OPC_RANDOM, x, nn};
            end else if (kind < 88) begin
               op = {OPC_DRAW, x, 4'($urandom), rows};
            end else begin
               nib = 4'($urandom);
               while (nib == OPC_JUMP || nib == OPC_SKIP_EQ || nib == OPC_ADD_IMM ||
                      nib == OPC_SET_INDEX || nib == OPC_RANDOM || nib == OPC_DRAW)
                  nib = 4'($urandom);
               op = {nib, 12'($urandom)};
            end
            // fresh sprite bytes for some draws
            if (op[15:12] == OPC_DRAW && $urandom_range(1) != 0) begin
               for (int i = 0; i < rows; i++) load_byte(sb.index_reg + i, 8'($urandom));
            end
            load_word(sb.pc, op);
            step_once();
         end else if (pick < 72) begin
            // run whatever memory holds
            step_once();
         end else if (pick < 82) begin
            load_byte($urandom_range(4095), 8'($urandom));
         end else if (pick < 97) begin
            read_row($urandom_range(DISP_H - 1));
         end else begin
            send_request(REQ_UNUSED, ADDR_W'($urandom), 8'($urandom), ROW_W'($urandom));
         end
      end
   endtask

   initial begin
      sb = new();
      reset = 1'b1;
      req_valid = 1'b0;
      req_type = REQ_LOAD;
      req_address = '0;
      req_data = '0;
      req_row = '0;
      rsp_ready = 1'b0;
      csr_valid = 1'b0;
      csr_index = CSR_START_ADDRESS;
      csr_wdata = '0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed program at the reset start address
      read_row(DISP_H - 1);
      send_request(REQ_UNUSED, '1, 8'hFF, '1);
      load_word(512, {OPC_ADD_IMM, 4'h1, 8'hFE});
      load_word(514, {OPC_ADD_IMM, 4'h2, 8'hFF});
      load_word(516, {OPC_SKIP_EQ, 4'h1, 8'hFE});
      load_word(520, {OPC_SET_INDEX, 12'hFFF});
      load_word(522, {OPC_DRAW, 4'h1, 4'h2, 4'h2});
      load_word(524, {OPC_DRAW, 4'h1, 4'h2, 4'h2});
      load_word(526, {OPC_DRAW, 4'h1, 4'h2, 4'h0});
      load_word(528, {OPC_RANDOM, 4'h3, 8'hFF});
      load_word(530, {OPC_JUMP, 12'hFFF});
      // sprite rows straddle the top of memory
      load_byte('hFFF, 8'hFF);
      load_byte(0, 8'hC3);
      // the draw wraps in both directions, the second draw collides,
      // the last step fetches across the end of memory
      repeat (6) step_once();
      read_row(0);
      repeat (4) step_once();
      read_row(DISP_H - 1);

      run_phase(12'd0, 16'd0, 0, 0, 400);
      run_phase(12'd4094, 16'hFFFF, 50, 0, 400);
      run_phase(12'($urandom_range(4094)), 16'd1, 0, 50, 400);
      run_phase(12'($urandom_range(4094)), 16'($urandom_range(65535, 1)), 14, 14, 400);
      run_phase(12'($urandom_range(4094)), 16'($urandom_range(65535, 1)), 0, 0, 400);

      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.mismatches == 0 && sb.pending_results.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

// ===== chip8_instruction_subset_executor_unit.f =====
design/c8ise_pkg.sv
design/c8ise_dpath.sv
design/c8ise_ctrl.sv
design/chip8_instruction_subset_executor_unit.sv
design/c8ise_checker.sv
tb/chip8_instruction_subset_executor_unit_tb.sv
